[design/ucft_pkg.sv]
package ucft_pkg;

    localparam logic [7:0] START_TICKS_RESET = 8'd14;
    localparam logic [7:0] BIT_TICKS_RESET   = 8'd14;
    localparam logic [7:0] STOP_TICKS_RESET  = 8'd0;

    localparam logic [1:0] REG_START_TICKS = 2'd0;
    localparam logic [1:0] REG_BIT_TICKS   = 2'd1;
    localparam logic [1:0] REG_STOP_TICKS  = 2'd2;

    localparam logic [3:0] PHASE_START     = 4'd0;
    localparam logic [3:0] PHASE_FIRST_DATA = 4'd1;
    localparam logic [3:0] PHASE_LAST_DATA = 4'd8;
    localparam logic [3:0] PHASE_STOP      = 4'd9;

    localparam logic [2:0] FRAME_LAST = 3'd7;

    localparam logic [7:0] FRAME_SYNC   = 8'h7E;
    localparam logic [7:0] FRAME_ADDR   = 8'hFF;
    localparam logic [7:0] FRAME_LEN    = 8'h06;
    localparam logic [7:0] FRAME_ZERO   = 8'h00;
    localparam logic [7:0] FRAME_END    = 8'hEF;
    localparam logic [7:0] TICK_SAT     = 8'hFF;

    typedef struct packed {
        logic [7:0] start_ticks;
        logic [7:0] bit_ticks;
        logic [7:0] stop_ticks;
    } cfg_t;

    typedef struct packed {
        logic       active;
        logic       mode;
        logic [2:0] pos;
        logic [3:0] phase;
        logic [7:0] tick_count;
        logic [7:0] shift_byte;
        logic [7:0] command;
        logic [7:0] data_byte;
    } tx_state_t;

    typedef struct packed {
        logic start_req;
        logic frame_mode;
        logic [7:0] command;
        logic [7:0] data_byte;
    } tick_in_t;

    typedef struct packed {
        logic tx_line;
        logic busy_res;
        logic done_res;
    } tick_out_t;

    function automatic logic [7:0] frame_byte(input logic [2:0] pos,
                                              input logic [7:0] command,
                                              input logic [7:0] data_byte);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = FRAME_SYNC;
            3'd1:    b = FRAME_ADDR;
            3'd2:    b = FRAME_LEN;
            3'd3:    b = command;
            3'd4:    b = FRAME_ZERO;
            3'd5:    b = FRAME_ZERO;
            3'd6:    b = data_byte;
            default: b = FRAME_END;
        endcase
        return b;
    endfunction

endpackage

[design/uart_command_frame_transmitter_top.sv]
// Channel  Direction  Signals                         Content
// s        in         s_tvalid s_tready s_tdata s_tuser  one tick: request, command, data byte
// m        out        m_tvalid m_tready m_tdata m_tlast  line level and busy for that tick
// cfg      in         cfg_valid cfg_ready cfg_index cfg_data  tick counts per bit phase
//
// Every accepted item is one tick of the bit clock and yields one result item in the next
// cycle; one item is taken per cycle unless m_tready stalls. Transmitter state and result
// are updated together from the tick logic, and the result waits in an output register.
// The input side is ready whenever that output register is empty or being drained.
// Reset makes the transmitter idle, clears the output register and loads the default tick counts.
module uart_command_frame_transmitter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // start_req[0], command[8:1], data_byte[16:9], zeros
    input  logic        s_tuser,   // frame_mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_line[0], busy_res[1], zeros
    output logic        m_tlast,   // done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    ucft_pkg::cfg_t      cfg_reg;
    ucft_pkg::tx_state_t state_reg;
    ucft_pkg::tx_state_t state_next;
    ucft_pkg::tick_in_t  tin;
    ucft_pkg::tick_out_t res_next;
    ucft_pkg::tick_out_t res_reg;
    logic                m_tvalid_reg;
    logic                accept;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign tin.start_req  = s_tdata[0];
    assign tin.frame_mode = s_tuser;
    assign tin.command    = s_tdata[8:1];
    assign tin.data_byte  = s_tdata[16:9];

    ucft_tick u_tick (
        .cfg (cfg_reg),
        .cur (state_reg),
        .tin (tin),
        .nxt (state_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_ticks <= ucft_pkg::START_TICKS_RESET;
            cfg_reg.bit_ticks   <= ucft_pkg::BIT_TICKS_RESET;
            cfg_reg.stop_ticks  <= ucft_pkg::STOP_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ucft_pkg::REG_START_TICKS: cfg_reg.start_ticks <= cfg_data;
                ucft_pkg::REG_BIT_TICKS:   cfg_reg.bit_ticks   <= cfg_data;
                ucft_pkg::REG_STOP_TICKS:  cfg_reg.stop_ticks  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg    <= state_next;
                res_reg      <= res_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, res_reg.busy_res, res_reg.tx_line};
    assign m_tlast  = res_reg.done_res;

endmodule

[design/ucft_tick.sv]
module ucft_tick (
    input  ucft_pkg::cfg_t      cfg,
    input  ucft_pkg::tx_state_t cur,
    input  ucft_pkg::tick_in_t  tin,
    output ucft_pkg::tx_state_t nxt,
    output ucft_pkg::tick_out_t res
);

    always_comb
    begin
        ucft_pkg::tx_state_t s;
        logic [7:0] len;
        logic [7:0] tc1;
        logic       phase_end;
        logic       byte_end;

        s = cur;
        res.tx_line  = 1'b1;
        res.busy_res = 1'b0;
        res.done_res = 1'b0;
        len = 8'd0;
        tc1 = 8'd0;
        phase_end = 1'b0;
        byte_end = 1'b0;

        // A request is only taken while the line is idle.
        if (!cur.active && tin.start_req)
        begin
            s.active     = 1'b1;
            s.mode       = tin.frame_mode;
            s.command    = tin.command;
            s.data_byte  = tin.data_byte;
            s.pos        = 3'd0;
            s.phase      = ucft_pkg::PHASE_START;
            s.tick_count = 8'd0;
            s.shift_byte = tin.frame_mode ? ucft_pkg::FRAME_SYNC : tin.data_byte;
        end

        if (s.active)
        begin
            res.busy_res = 1'b1;
            priority if (s.phase == ucft_pkg::PHASE_START)
            begin
                res.tx_line = 1'b0;
                len = cfg.start_ticks;
            end
            else if (s.phase == ucft_pkg::PHASE_STOP)
            begin
                res.tx_line = 1'b1;
                len = cfg.stop_ticks;
            end
            else
            begin
                res.tx_line = s.shift_byte[0];
                len = cfg.bit_ticks;
            end
            if (len == 8'd0)
            begin
                len = 8'd1;
            end

            tc1 = (s.tick_count != ucft_pkg::TICK_SAT) ? s.tick_count + 8'd1 : s.tick_count;
            phase_end = (tc1 >= len);
            s.tick_count = phase_end ? 8'd0 : tc1;

            if (phase_end)
            begin
                priority if (s.phase == ucft_pkg::PHASE_START)
                begin
                    s.phase = ucft_pkg::PHASE_FIRST_DATA;
                end
                else if (s.phase < ucft_pkg::PHASE_LAST_DATA)
                begin
                    s.shift_byte = {1'b0, s.shift_byte[7:1]};
                    s.phase = s.phase + 4'd1;
                end
                else if (s.phase == ucft_pkg::PHASE_LAST_DATA)
                begin
                    s.shift_byte = {1'b0, s.shift_byte[7:1]};
                    if (cfg.stop_ticks != 8'd0)
                    begin
                        s.phase = ucft_pkg::PHASE_STOP;
                    end
                    else
                    begin
                        byte_end = 1'b1;
                    end
                end
                else
                begin
                    byte_end = 1'b1;
                end
            end

            if (byte_end)
            begin
                s.phase = ucft_pkg::PHASE_START;
                if (!s.mode || s.pos == ucft_pkg::FRAME_LAST)
                begin
                    s.active = 1'b0;
                    s.pos = 3'd0;
                    res.done_res = 1'b1;
                end
                else
                begin
                    s.pos = s.pos + 3'd1;
                    s.shift_byte = ucft_pkg::frame_byte(s.pos, s.command, s.data_byte);
                end
            end
        end

        nxt = s;
    end

endmodule
